// File: rtl/core/trs_transform_compose_top_assert.svh
// assertion macros for the transform compose block
`ifndef TRS_TRANSFORM_COMPOSE_TOP_ASSERT_SVH
`define TRS_TRANSFORM_COMPOSE_TOP_ASSERT_SVH

// same-cycle implication
`define TRS_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trs transform compose: check failed");

// next-cycle implication
`define TRS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trs transform compose: check failed");

`endif

// File: rtl/core/trs_pkg.sv
package trs_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 10;
   localparam int ACC_W     = 52;
   localparam int ADDR_W    = 6;

   localparam logic [WORD_W-1:0] FX_ONE = 32'h0001_0000;

   // working memory map; addresses with the top two bits clear are the
   // accumulator words and get the bank bit patched into bit 4
   localparam logic [ADDR_W-1:0] A_SX = 6'd0;
   localparam logic [ADDR_W-1:0] A_SY = 6'd1;
   localparam logic [ADDR_W-1:0] A_SZ = 6'd2;
   localparam logic [ADDR_W-1:0] A_QX = 6'd3;
   localparam logic [ADDR_W-1:0] A_QY = 6'd4;
   localparam logic [ADDR_W-1:0] A_QZ = 6'd5;
   localparam logic [ADDR_W-1:0] A_QW = 6'd6;
   localparam logic [ADDR_W-1:0] A_TX = 6'd7;
   localparam logic [ADDR_W-1:0] A_TY = 6'd8;
   localparam logic [ADDR_W-1:0] A_TZ = 6'd9;
   localparam logic [ADDR_W-1:0] A_RSX = 6'd32;
   localparam logic [ADDR_W-1:0] A_RSY = 6'd33;
   localparam logic [ADDR_W-1:0] A_RSZ = 6'd34;
   localparam logic [ADDR_W-1:0] A_RQX = 6'd35;
   localparam logic [ADDR_W-1:0] A_RQY = 6'd36;
   localparam logic [ADDR_W-1:0] A_RQZ = 6'd37;
   localparam logic [ADDR_W-1:0] A_RQW = 6'd38;
   localparam logic [ADDR_W-1:0] A_RTX = 6'd39;
   localparam logic [ADDR_W-1:0] A_RTY = 6'd40;
   localparam logic [ADDR_W-1:0] A_RTZ = 6'd41;
   localparam logic [ADDR_W-1:0] A_ONE = 6'd42;
   localparam logic [ADDR_W-1:0] A_M00 = 6'd48;
   localparam logic [ADDR_W-1:0] A_M01 = 6'd49;
   localparam logic [ADDR_W-1:0] A_M02 = 6'd50;
   localparam logic [ADDR_W-1:0] A_M10 = 6'd51;
   localparam logic [ADDR_W-1:0] A_M11 = 6'd52;
   localparam logic [ADDR_W-1:0] A_M12 = 6'd53;
   localparam logic [ADDR_W-1:0] A_M20 = 6'd54;
   localparam logic [ADDR_W-1:0] A_M21 = 6'd55;
   localparam logic [ADDR_W-1:0] A_M22 = 6'd56;
   localparam logic [ADDR_W-1:0] A_VX = 6'd57;
   localparam logic [ADDR_W-1:0] A_VY = 6'd58;
   localparam logic [ADDR_W-1:0] A_VZ = 6'd59;

   localparam logic [5:0] UOP_LAST = 6'd54;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_IDENT   = 2'd1,
      MODE_COMPOSE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic [ADDR_W-1:0] dest;
      logic              neg;
      logic              dbl;
      logic              first;
      logic              last;
   } uop_type;

   typedef struct packed {
      logic        idle;
      logic        init;
      logic        fill;
      logic        issue;
      logic        finish;
      mode_type    mode;
      logic [3:0]  idx;
      uop_type     uop;
   } ctl_type;

   typedef struct packed {
      logic              we;
      logic              stage;
      logic [3:0]        idx;
      logic [WORD_W-1:0] data;
   } wb_type;

   function automatic uop_type mk(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                  input logic neg, input logic dbl, input logic first,
                                  input logic last, input logic [ADDR_W-1:0] dest);
      uop_type u;
      u.addr_a = a;
      u.addr_b = b;
      u.dest   = dest;
      u.neg    = neg;
      u.dbl    = dbl;
      u.first  = first;
      u.last   = last;
      return u;
   endfunction

   // one product per entry: rotation matrix, scaled vector, hamilton product,
   // scale, then translation
   function automatic uop_type uop_rom(input logic [5:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(A_ONE, A_ONE, 1'b0, 1'b0, 1'b1, 1'b0, A_M00);
         6'd1:  u = mk(A_QY,  A_QY,  1'b1, 1'b1, 1'b0, 1'b0, A_M00);
         6'd2:  u = mk(A_QZ,  A_QZ,  1'b1, 1'b1, 1'b0, 1'b1, A_M00);
         6'd3:  u = mk(A_QX,  A_QY,  1'b0, 1'b1, 1'b1, 1'b0, A_M01);
         6'd4:  u = mk(A_QW,  A_QZ,  1'b1, 1'b1, 1'b0, 1'b1, A_M01);
         6'd5:  u = mk(A_QX,  A_QZ,  1'b0, 1'b1, 1'b1, 1'b0, A_M02);
         6'd6:  u = mk(A_QW,  A_QY,  1'b0, 1'b1, 1'b0, 1'b1, A_M02);
         6'd7:  u = mk(A_QX,  A_QY,  1'b0, 1'b1, 1'b1, 1'b0, A_M10);
         6'd8:  u = mk(A_QW,  A_QZ,  1'b0, 1'b1, 1'b0, 1'b1, A_M10);
         6'd9:  u = mk(A_ONE, A_ONE, 1'b0, 1'b0, 1'b1, 1'b0, A_M11);
         6'd10: u = mk(A_QX,  A_QX,  1'b1, 1'b1, 1'b0, 1'b0, A_M11);
         6'd11: u = mk(A_QZ,  A_QZ,  1'b1, 1'b1, 1'b0, 1'b1, A_M11);
         6'd12: u = mk(A_QY,  A_QZ,  1'b0, 1'b1, 1'b1, 1'b0, A_M12);
         6'd13: u = mk(A_QW,  A_QX,  1'b1, 1'b1, 1'b0, 1'b1, A_M12);
         6'd14: u = mk(A_QX,  A_QZ,  1'b0, 1'b1, 1'b1, 1'b0, A_M20);
         6'd15: u = mk(A_QW,  A_QY,  1'b1, 1'b1, 1'b0, 1'b1, A_M20);
         6'd16: u = mk(A_QY,  A_QZ,  1'b0, 1'b1, 1'b1, 1'b0, A_M21);
         6'd17: u = mk(A_QW,  A_QX,  1'b0, 1'b1, 1'b0, 1'b1, A_M21);
         6'd18: u = mk(A_ONE, A_ONE, 1'b0, 1'b0, 1'b1, 1'b0, A_M22);
         6'd19: u = mk(A_QX,  A_QX,  1'b1, 1'b1, 1'b0, 1'b0, A_M22);
         6'd20: u = mk(A_QY,  A_QY,  1'b1, 1'b1, 1'b0, 1'b1, A_M22);
         6'd21: u = mk(A_SX,  A_RTX, 1'b0, 1'b0, 1'b1, 1'b1, A_VX);
         6'd22: u = mk(A_SY,  A_RTY, 1'b0, 1'b0, 1'b1, 1'b1, A_VY);
         6'd23: u = mk(A_SZ,  A_RTZ, 1'b0, 1'b0, 1'b1, 1'b1, A_VZ);
         6'd24: u = mk(A_QW,  A_RQW, 1'b0, 1'b0, 1'b1, 1'b0, A_QW);
         6'd25: u = mk(A_QX,  A_RQX, 1'b1, 1'b0, 1'b0, 1'b0, A_QW);
         6'd26: u = mk(A_QY,  A_RQY, 1'b1, 1'b0, 1'b0, 1'b0, A_QW);
         6'd27: u = mk(A_QZ,  A_RQZ, 1'b1, 1'b0, 1'b0, 1'b1, A_QW);
         6'd28: u = mk(A_QW,  A_RQX, 1'b0, 1'b0, 1'b1, 1'b0, A_QX);
         6'd29: u = mk(A_QX,  A_RQW, 1'b0, 1'b0, 1'b0, 1'b0, A_QX);
         6'd30: u = mk(A_QY,  A_RQZ, 1'b0, 1'b0, 1'b0, 1'b0, A_QX);
         6'd31: u = mk(A_QZ,  A_RQY, 1'b1, 1'b0, 1'b0, 1'b1, A_QX);
         6'd32: u = mk(A_QW,  A_RQY, 1'b0, 1'b0, 1'b1, 1'b0, A_QY);
         6'd33: u = mk(A_QX,  A_RQZ, 1'b1, 1'b0, 1'b0, 1'b0, A_QY);
         6'd34: u = mk(A_QY,  A_RQW, 1'b0, 1'b0, 1'b0, 1'b0, A_QY);
         6'd35: u = mk(A_QZ,  A_RQX, 1'b0, 1'b0, 1'b0, 1'b1, A_QY);
         6'd36: u = mk(A_QW,  A_RQZ, 1'b0, 1'b0, 1'b1, 1'b0, A_QZ);
         6'd37: u = mk(A_QX,  A_RQY, 1'b0, 1'b0, 1'b0, 1'b0, A_QZ);
         6'd38: u = mk(A_QY,  A_RQX, 1'b1, 1'b0, 1'b0, 1'b0, A_QZ);
         6'd39: u = mk(A_QZ,  A_RQW, 1'b0, 1'b0, 1'b0, 1'b1, A_QZ);
         6'd40: u = mk(A_SX,  A_RSX, 1'b0, 1'b0, 1'b1, 1'b1, A_SX);
         6'd41: u = mk(A_SY,  A_RSY, 1'b0, 1'b0, 1'b1, 1'b1, A_SY);
         6'd42: u = mk(A_SZ,  A_RSZ, 1'b0, 1'b0, 1'b1, 1'b1, A_SZ);
         6'd43: u = mk(A_TX,  A_ONE, 1'b0, 1'b0, 1'b1, 1'b0, A_TX);
         6'd44: u = mk(A_M00, A_VX,  1'b0, 1'b0, 1'b0, 1'b0, A_TX);
         6'd45: u = mk(A_M01, A_VY,  1'b0, 1'b0, 1'b0, 1'b0, A_TX);
         6'd46: u = mk(A_M02, A_VZ,  1'b0, 1'b0, 1'b0, 1'b1, A_TX);
         6'd47: u = mk(A_TY,  A_ONE, 1'b0, 1'b0, 1'b1, 1'b0, A_TY);
         6'd48: u = mk(A_M10, A_VX,  1'b0, 1'b0, 1'b0, 1'b0, A_TY);
         6'd49: u = mk(A_M11, A_VY,  1'b0, 1'b0, 1'b0, 1'b0, A_TY);
         6'd50: u = mk(A_M12, A_VZ,  1'b0, 1'b0, 1'b0, 1'b1, A_TY);
         6'd51: u = mk(A_TZ,  A_ONE, 1'b0, 1'b0, 1'b1, 1'b0, A_TZ);
         6'd52: u = mk(A_M20, A_VX,  1'b0, 1'b0, 1'b0, 1'b0, A_TZ);
         6'd53: u = mk(A_M21, A_VY,  1'b0, 1'b0, 1'b0, 1'b0, A_TZ);
         6'd54: u = mk(A_M22, A_VZ,  1'b0, 1'b0, 1'b0, 1'b1, A_TZ);
         default: u = '0;
      endcase
      return u;
   endfunction

   function automatic logic [WORD_W-1:0] ident_word(input logic [3:0] idx);
      logic [WORD_W-1:0] w;
      if (idx == A_SX[3:0] || idx == A_SY[3:0] || idx == A_SZ[3:0] || idx == A_QW[3:0]) begin
         w = FX_ONE;
      end else begin
         w = '0;
      end
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [WORD_W-1:0] w;
      if (&v[ACC_W-1:WORD_W-1] || ~|v[ACC_W-1:WORD_W-1]) begin
         w = v[WORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         w = 32'h8000_0000;
      end else begin
         w = 32'h7fff_ffff;
      end
      return w;
   endfunction

endpackage

// File: rtl/core/trs_seq.sv
module trs_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  trs_pkg::mode_type   mode_in,
   input  logic                rsp_free,
   output trs_pkg::ctl_type    ctl
);
   import trs_pkg::*;

   typedef enum logic [5:0] {
      S_INIT  = 6'b000001,
      S_IDLE  = 6'b000010,
      S_FILL  = 6'b000100,
      S_RUN   = 6'b001000,
      S_DRAIN = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [5:0] pc_ff, pc_in;
   mode_type   mode_ff, mode_in_q;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pc_in     = pc_ff;
      mode_in_q = mode_ff;
      case (state_ff)
         S_INIT: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in  = S_FILL;
               cnt_in    = '0;
               mode_in_q = mode_in;
            end
         end
         S_FILL: begin
            cnt_in = cnt_ff + 4'd1;
            if (mode_ff != MODE_COMPOSE && cnt_ff == 4'd9) begin
               state_in = S_DONE;
            end else if (mode_ff == MODE_COMPOSE && cnt_ff == 4'd10) begin
               state_in = S_RUN;
               pc_in    = '0;
            end
         end
         S_RUN: begin
            pc_in = pc_ff + 6'd1;
            if (pc_ff == UOP_LAST) begin
               state_in = S_DRAIN;
               cnt_in   = '0;
            end
         end
         S_DRAIN: begin
            // wait for the last products to leave the multiplier pipe
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         pc_ff    <= '0;
         mode_ff  <= MODE_LOAD;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pc_ff    <= pc_in;
         mode_ff  <= mode_in_q;
      end
   end

   always_comb begin
      ctl.idle   = (state_ff == S_IDLE);
      ctl.init   = (state_ff == S_INIT);
      ctl.fill   = (state_ff == S_FILL);
      ctl.issue  = (state_ff == S_RUN);
      ctl.finish = (state_ff == S_DONE) && rsp_free;
      ctl.mode   = mode_ff;
      ctl.idx    = cnt_ff;
      ctl.uop    = uop_rom(pc_ff);
   end

endmodule

// File: rtl/core/trs_mac.sv
module trs_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               bank,
   input  logic                               issue,
   input  trs_pkg::uop_type                   uop,
   input  logic                               fill_we,
   input  logic [trs_pkg::ADDR_W-1:0]         fill_addr,
   input  logic [trs_pkg::WORD_W-1:0]         fill_data,
   output trs_pkg::wb_type                    wb
);
   import trs_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [ADDR_W-1:0]        rd_addr_a, rd_addr_b, wr_addr, wb_addr;
   logic [WORD_W-1:0]        wr_data;
   logic                     wr_en;
   logic [WORD_W-1:0]        rd_a_ff, rd_b_ff;
   logic                     v1_ff, v2_ff;
   uop_type                  u1_ff, u2_ff;
   logic signed [63:0]       prod_ff;
   logic signed [63:0]       rnd_q;
   logic signed [ACC_W-1:0]  term, acc_ff, acc_in;

   // accumulator words live in two banks; reads use the current one
   always_comb begin
      rd_addr_a = uop.addr_a;
      rd_addr_b = uop.addr_b;
      if (uop.addr_a[5:4] == 2'b00) rd_addr_a = {1'b0, bank, uop.addr_a[3:0]};
      if (uop.addr_b[5:4] == 2'b00) rd_addr_b = {1'b0, bank, uop.addr_b[3:0]};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      u1_ff   <= uop;
      u2_ff   <= u1_ff;
      prod_ff <= $signed(rd_a_ff) * $signed(rd_b_ff);
      if (v2_ff) acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   // round half up to q16.16, then optional doubling and negation
   always_comb begin
      rnd_q = prod_ff + 64'sd32768;
      term  = ACC_W'($signed(rnd_q[63:16]));
      if (u2_ff.dbl) term = term <<< 1;
      if (u2_ff.neg) term = -term;
      acc_in = (u2_ff.first ? '0 : acc_ff) + term;
   end

   always_comb begin
      wb.we    = v2_ff && u2_ff.last;
      wb.stage = (u2_ff.dest[5:4] == 2'b00);
      wb.idx   = u2_ff.dest[3:0];
      wb.data  = sat32(acc_in);
      wb_addr  = wb.stage ? {1'b0, ~bank, u2_ff.dest[3:0]} : u2_ff.dest;
      wr_en    = wb.we || fill_we;
      wr_addr  = wb.we ? wb_addr : fill_addr;
      wr_data  = wb.we ? wb.data : fill_data;
   end

endmodule

// File: rtl/core/trs_transform_compose_top.sv
// channel | ports                        | contents
// request | req_tvalid/tready/tdata/tuser | transform to load or compose
// result  | rsp_tvalid/tready/tdata/tuser | accumulated transform after step
//
// a load or identity request shows its result after 10 fill writes and the
// handoff, a compose after 11 fill writes, 55 products through the one
// shared 32x32 multiplier, the pipe drain and the handoff; the sequencer
// then returns to idle.
// after reset an init pass writes the identity into the working memory,
// req_tready stays low meanwhile.
// one request at a time; a result held by rsp_tready low only stalls the
// next request at its handoff.
module trs_transform_compose_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_scale_x/y/z, in_quat_x/y/z/w, in_move_x/y/z, 32 bits each
   input  logic [319:0] req_tdata,
   // opcode, in_dirty
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_scale_x/y/z, out_quat_x/y/z/w, out_move_x/y/z, 32 bits each
   output logic [319:0] rsp_tdata,
   // out_dirty
   output logic [0:0]   rsp_tuser
);
   import trs_pkg::*;

   ctl_type            ctl;
   wb_type             wb;
   mode_type           mode;
   logic               accept, rsp_free;
   logic               bank_ff, acc_dirty_ff, in_dirty_ff, rsp_dirty_ff, rsp_valid_ff;
   logic [WORD_W-1:0]  in_word_ff  [NUM_WORDS];
   logic [WORD_W-1:0]  stage_ff    [NUM_WORDS];
   logic [WORD_W-1:0]  rsp_word_ff [NUM_WORDS];
   logic               fill_we;
   logic [ADDR_W-1:0]  fill_addr;
   logic [WORD_W-1:0]  fill_data;
   logic               fill_stage;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = ctl.idle;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (!req_tuser[0]) begin
         mode = MODE_LOAD;
      end else if (!acc_dirty_ff && !req_tuser[1]) begin
         mode = MODE_IDENT;
      end else begin
         mode = MODE_COMPOSE;
      end
   end

   trs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .mode_in  (mode),
      .rsp_free (rsp_free),
      .ctl      (ctl)
   );

   // fill: identity at init, the input words or identity for the new bank,
   // or the right operand plus the constant one ahead of a compose
   always_comb begin
      fill_we    = ctl.init || ctl.fill;
      fill_stage = ctl.fill && (ctl.mode != MODE_COMPOSE);
      fill_addr  = {1'b0, ~bank_ff, ctl.idx};
      fill_data  = ident_word(ctl.idx);
      if (ctl.init) begin
         fill_addr = {1'b0, bank_ff, ctl.idx};
      end else if (ctl.mode == MODE_COMPOSE) begin
         fill_addr = {2'b10, ctl.idx};
         fill_data = (ctl.idx == A_ONE[3:0]) ? FX_ONE : in_word_ff[ctl.idx];
      end else if (ctl.mode == MODE_LOAD) begin
         fill_data = in_word_ff[ctl.idx];
      end
   end

   trs_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .bank      (bank_ff),
      .issue     (ctl.issue),
      .uop       (ctl.uop),
      .fill_we   (fill_we),
      .fill_addr (fill_addr),
      .fill_data (fill_data),
      .wb        (wb)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            in_word_ff[i] <= req_tdata[i*WORD_W +: WORD_W];
         end
         in_dirty_ff <= req_tuser[1];
      end
      if (fill_stage) stage_ff[ctl.idx] <= fill_data;
      if (wb.we && wb.stage) stage_ff[wb.idx] <= wb.data;
      if (ctl.finish) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            rsp_word_ff[i] <= stage_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         acc_dirty_ff <= 1'b0;
         rsp_dirty_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.finish) begin
            bank_ff      <= ~bank_ff;
            rsp_valid_ff <= 1'b1;
            case (ctl.mode)
               MODE_LOAD: begin
                  acc_dirty_ff <= in_dirty_ff;
                  rsp_dirty_ff <= in_dirty_ff;
               end
               MODE_IDENT: begin
                  acc_dirty_ff <= 1'b0;
                  rsp_dirty_ff <= 1'b0;
               end
               default: begin
                  acc_dirty_ff <= 1'b1;
                  rsp_dirty_ff <= 1'b1;
               end
            endcase
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_dirty_ff;

   for (genvar g = 0; g < NUM_WORDS; g++) begin : g_rsp
      assign rsp_tdata[g*WORD_W +: WORD_W] = rsp_word_ff[g];
   end

`include "trs_transform_compose_top_assert.svh"

   `TRS_ASSERT_IMPLIES(a_wb_in_run, wb.we, !ctl.idle && !ctl.init && !ctl.fill)
   `TRS_ASSERT_NEXT(a_finish_shows, ctl.finish, rsp_tvalid)
   `TRS_ASSERT_NEXT(a_bank_holds, !ctl.finish, $stable(bank_ff))
   `TRS_ASSERT_IMPLIES(a_one_phase, 1'b1, $onehot0({ctl.idle, ctl.init, ctl.fill, ctl.issue}))

endmodule

// File: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import trs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPOSE = 1'b1;
   localparam logic [31:0] FX_MAX_W = 32'h7fff_ffff;
   localparam logic [31:0] FX_MIN_W = 32'h8000_0000;

   typedef struct {
      logic [31:0] scale[3];
      logic [31:0] quat[4];
      logic [31:0] move[3];
      logic        dirty;
   } xform_type;

   typedef struct {
      logic      op;
      xform_type xf;
      logic      check_typed;
      xform_type typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [319:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [319:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   xform_type acc_xf;
   xform_type expected_xforms[$];
   stim_row_type table_rows[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;

   trs_transform_compose_top i_dut (.*);

   always #10 clock = ~clock;

   function automatic logic signed [63:0] sx(input logic [31:0] w);
      return {{32{w[31]}}, w};
   endfunction

   function automatic logic [31:0] clamp(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return FX_MAX_W;
      if (v < -64'sd2147483648) return FX_MIN_W;
      return v[31:0];
   endfunction

   // rounded q16.16 product, ties toward plus infinity
   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd32768;
      return p >>> 16;
   endfunction

   function automatic xform_type identity_xf();
      xform_type t;
      for (int i = 0; i < 3; i++) begin
         t.scale[i] = FX_ONE;
         t.move[i] = '0;
      end
      t.quat = '{32'd0, 32'd0, 32'd0, FX_ONE};
      t.dirty = 1'b0;
      return t;
   endfunction

   function automatic xform_type compose_xf(input xform_type l, input xform_type r);
      xform_type t;
      logic signed [63:0] x, y, z, w, rx, ry, rz, rw, one;
      logic signed [63:0] m[3][3];
      logic signed [63:0] v[3];
      x = sx(l.quat[0]); y = sx(l.quat[1]); z = sx(l.quat[2]); w = sx(l.quat[3]);
      rx = sx(r.quat[0]); ry = sx(r.quat[1]); rz = sx(r.quat[2]); rw = sx(r.quat[3]);
      one = 64'sd65536;
      m[0][0] = sx(clamp(one - 2 * (qmul(y, y) + qmul(z, z))));
      m[0][1] = sx(clamp(2 * (qmul(x, y) - qmul(w, z))));
      m[0][2] = sx(clamp(2 * (qmul(x, z) + qmul(w, y))));
      m[1][0] = sx(clamp(2 * (qmul(x, y) + qmul(w, z))));
      m[1][1] = sx(clamp(one - 2 * (qmul(x, x) + qmul(z, z))));
      m[1][2] = sx(clamp(2 * (qmul(y, z) - qmul(w, x))));
      m[2][0] = sx(clamp(2 * (qmul(x, z) - qmul(w, y))));
      m[2][1] = sx(clamp(2 * (qmul(y, z) + qmul(w, x))));
      m[2][2] = sx(clamp(one - 2 * (qmul(x, x) + qmul(y, y))));
      for (int i = 0; i < 3; i++) v[i] = sx(clamp(qmul(sx(l.scale[i]), sx(r.move[i]))));
      t.quat[3] = clamp(qmul(w, rw) - qmul(x, rx) - qmul(y, ry) - qmul(z, rz));
      t.quat[0] = clamp(qmul(w, rx) + qmul(x, rw) + qmul(y, rz) - qmul(z, ry));
      t.quat[1] = clamp(qmul(w, ry) - qmul(x, rz) + qmul(y, rw) + qmul(z, rx));
      t.quat[2] = clamp(qmul(w, rz) + qmul(x, ry) - qmul(y, rx) + qmul(z, rw));
      for (int i = 0; i < 3; i++) begin
         t.scale[i] = clamp(qmul(sx(l.scale[i]), sx(r.scale[i])));
         t.move[i] = clamp(sx(l.move[i]) + qmul(m[i][0], v[0]) + qmul(m[i][1], v[1])
                           + qmul(m[i][2], v[2]));
      end
      t.dirty = 1'b1;
      return t;
   endfunction

   function automatic void advance_acc(input logic op, input xform_type r);
      if (op == OP_LOAD) acc_xf = r;
      else if (!acc_xf.dirty && !r.dirty) acc_xf = identity_xf();
      else acc_xf = compose_xf(acc_xf, r);
   endfunction

   function automatic logic [319:0] pack_xf(input xform_type t);
      logic [319:0] d;
      for (int i = 0; i < 3; i++) begin
         d[32*i +: 32] = t.scale[i];
         d[32*(7+i) +: 32] = t.move[i];
      end
      for (int i = 0; i < 4; i++) d[32*(3+i) +: 32] = t.quat[i];
      return d;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return FX_MAX_W;
         1: return FX_MIN_W;
         2: return 32'(int'($urandom_range(0, 131072)) - 65536);
         3, 4: return 32'(int'($urandom_range(0, 8388608)) - 4194304);
         default: return $urandom();
      endcase
   endfunction

   // mostly quaternions with components within about +-0.707 so composition chains stay meaningful
   function automatic xform_type rand_xf();
      xform_type t;
      bit tame;
      tame = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 3; i++) begin
         t.scale[i] = tame ? 32'(int'($urandom_range(0, 262144)) - 131072) : rand_word();
         t.move[i] = tame ? 32'(int'($urandom_range(0, 2097152)) - 1048576) : rand_word();
      end
      for (int i = 0; i < 4; i++)
         t.quat[i] = tame ? 32'(int'($urandom_range(0, 92682)) - 46341) : rand_word();
      t.dirty = ($urandom_range(0, 4) != 0);
      return t;
   endfunction

   function automatic void add_row(input logic op, input xform_type t,
                                   input bit typed_ok, input xform_type typed);
      stim_row_type r;
      r.op = op; r.xf = t; r.check_typed = typed_ok; r.typed = typed;
      table_rows.push_back(r);
   endfunction

   task automatic send_request(input logic op, input xform_type t);
      req_tdata <= pack_xf(t);
      req_tuser <= {t.dirty, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_acc(op, t);
      expected_xforms.push_back(acc_xf);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      xform_type want;
      logic [319:0] want_d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_xforms.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = expected_xforms.pop_front();
            want_d = pack_xf(want);
            for (int i = 0; i < 10; i++)
               if (rsp_tdata[32*i +: 32] !== want_d[32*i +: 32]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("word %0d: expected %h got %h", i, want_d[32*i +: 32],
                              rsp_tdata[32*i +: 32]);
               end
            if (rsp_tuser[0] !== want.dirty) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("dirty: expected %b got %b", want.dirty, rsp_tuser[0]);
            end
         end
      end
   end

   // receiver stalls in its own rhythm
   always @(negedge clock) begin
      int phase;
      phase = ($time / 20) % 400;
      if (phase < 80) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) < 60);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("trs_transform_compose_top test failed");
         $finish;
      end
   end

   initial begin
      xform_type t, id, z;
      id = identity_xf();
      z = id;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      acc_xf = identity_xf();

      // clean compose from reset yields identity
      add_row(OP_COMPOSE, id, 1'b1, id);
      // clean load stored as given
      t = id; t.scale = '{FX_MAX_W, FX_MIN_W, 32'd0}; t.quat = '{FX_MIN_W, FX_MAX_W, 32'd5, 32'd0};
      t.move = '{FX_MAX_W, FX_MIN_W, 32'hffff_ffff};
      add_row(OP_LOAD, t, 1'b1, t);
      // clean compose on clean accumulator
      add_row(OP_COMPOSE, t, 1'b1, id);
      // dirty load then compose by clean identity keeps it
      t = id; t.dirty = 1'b1; t.scale = '{32'h0002_0000, 32'h0000_8000, 32'hffff_0000};
      t.move = '{32'h0001_0000, 32'hfffe_0000, 32'h0003_0000};
      add_row(OP_LOAD, t, 1'b1, t);
      z = id; z.dirty = 1'b0;
      add_row(OP_COMPOSE, z, 1'b0, z);
      // saturation everywhere
      t.scale = '{FX_MAX_W, FX_MIN_W, FX_MAX_W}; t.quat = '{FX_MAX_W, FX_MIN_W, FX_MAX_W, FX_MIN_W};
      t.move = '{FX_MIN_W, FX_MAX_W, FX_MIN_W}; t.dirty = 1'b1;
      add_row(OP_LOAD, t, 1'b0, t);
      add_row(OP_COMPOSE, t, 1'b0, t);
      add_row(OP_COMPOSE, t, 1'b0, t);
      t.quat = '{32'h0000_b505, 32'd0, 32'd0, 32'h0000_b505}; t.scale = '{FX_ONE, FX_ONE, FX_ONE};
      t.move = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}; t.dirty = 1'b0;
      add_row(OP_COMPOSE, t, 1'b0, t);
      add_row(OP_COMPOSE, t, 1'b0, t);
      t.quat = '{32'h0002_0000, 32'h0003_0000, 32'hfff0_0000, 32'h0000_1000};
      add_row(OP_COMPOSE, t, 1'b0, t);
      add_row(OP_LOAD, id, 1'b1, id);

      foreach (table_rows[k]) begin
         send_request(table_rows[k].op, table_rows[k].xf);
         if (table_rows[k].check_typed && pack_xf(acc_xf) !== pack_xf(table_rows[k].typed)) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("table row %0d disagrees with predictor", k);
         end
         if ($urandom_range(0, 2) == 0) sender_gap();
      end

      for (int n = 0; n < 1340; n++) begin
         logic op;
         op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_COMPOSE;
         send_request(op, rand_xf());
         if (n == 600) begin
            req_tvalid <= 1'b0;
            while (expected_xforms.size() != 0) @(negedge clock);
         end else if ($urandom_range(0, 7) == 0) begin
            sender_gap();
         end
      end
      req_tvalid <= 1'b0;

      while (expected_xforms.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatch_count == 0) $display("trs_transform_compose_top test passed");
      else $display("trs_transform_compose_top test failed");
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/trs_pkg.sv
rtl/core/trs_seq.sv
rtl/core/trs_mac.sv
rtl/core/trs_transform_compose_top.sv
bench/testbench.sv
